FILE: rtl/core/fau_pkg.sv
package fau_pkg;

  localparam int unsigned NumW  = 16;
  localparam int unsigned DenW  = 15;
  localparam int unsigned WordW = 32;
  localparam int unsigned RdW   = 30;
  localparam int unsigned ShW   = 5;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_LCD = 2'd3
  } act_e;

  // operands of the GCD engine
  typedef enum logic {
    GSRC_DEN = 1'b0,
    GSRC_RES = 1'b1
  } gsrc_e;

  // where a finished quotient goes; also picks the dividend
  typedef enum logic [1:0] {
    DDST_QA  = 2'd0,
    DDST_QB  = 2'd1,
    DDST_MAG = 2'd2,
    DDST_RD  = 2'd3
  } ddst_e;

  typedef enum logic [1:0] {
    MSEL_P0 = 2'd0,
    MSEL_P1 = 2'd1,
    MSEL_P2 = 2'd2
  } msel_e;

  typedef enum logic [1:0] {
    OK_NORM = 2'd0,
    OK_ZERO = 2'd1,
    OK_LCD  = 2'd2,
    OK_ERR  = 2'd3
  } okind_e;

  typedef struct packed {
    logic   load_in;
    logic   gcd_load;
    gsrc_e  gcd_src;
    logic   gcd_step;
    logic   div_load;
    ddst_e  div_dst;
    logic   div_step;
    logic   mul_en;
    msel_e  mul_sel;
    logic   res_load;
    logic   out_load;
    okind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_last;
    logic rn_zero;
    logic is_lcd;
  } sts_t;

endpackage

FILE: rtl/core/fau_datapath.sv
module fau_datapath (
  input  logic                       clk_i,
  input  fau_pkg::cmd_t              cmd_i,
  output fau_pkg::sts_t              sts_o,
  input  logic [1:0]                 action_i,
  input  logic [fau_pkg::NumW-1:0]   num_a_i,
  input  logic [fau_pkg::DenW-1:0]   den_a_i,
  input  logic [fau_pkg::NumW-1:0]   num_b_i,
  input  logic [fau_pkg::DenW-1:0]   den_b_i,
  output logic [fau_pkg::WordW-1:0]  num_out_o,
  output logic [fau_pkg::RdW-1:0]    den_out_o,
  output logic                       status_o
);
  import fau_pkg::*;

  // operands
  act_e               act_q;
  logic signed [NumW-1:0] na_q, nb_q;
  logic [DenW-1:0]    da_q, db_q;

  // binary GCD engine
  logic [WordW-1:0]   gcd_a_q, gcd_b_q, gcd_res;
  logic [ShW-1:0]     gcd_k_q;
  logic [WordW-1:0]   g_q;
  logic               gcd_done;

  // restoring divider, divisor is g_q
  logic [WordW-1:0]   div_r_q, div_qt_q, div_rn, div_qn, div_src;
  logic [ShW-1:0]     div_cnt_q;
  ddst_e              div_dst_q;
  logic [WordW:0]     div_t, div_diff;
  logic               div_ge, div_last;

  // products and reduced result
  logic signed [NumW:0]       op_a, op_b;
  logic signed [2*NumW+1:0]   prod;
  logic signed [WordW-1:0]    p0_q, p1_q, p2_q, rn_w;
  logic [WordW-1:0]           mag_w, mag_q;
  logic [RdW-1:0]             rd_w, rd_q;
  logic [DenW-1:0]            qa_q, qb_q;
  logic                       neg_q;

  logic [WordW-1:0]   num_q;
  logic [RdW-1:0]     den_q;
  logic               st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q <= act_e'(action_i);
      na_q  <= num_a_i;
      da_q  <= den_a_i;
      nb_q  <= num_b_i;
      db_q  <= den_b_i;
    end
  end

  // GCD
  assign gcd_done = (gcd_a_q == '0) || (gcd_b_q == '0);
  assign gcd_res  = (gcd_a_q | gcd_b_q) << gcd_k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_load) begin
      gcd_k_q <= '0;
      if (cmd_i.gcd_src == GSRC_DEN) begin
        gcd_a_q <= {{(WordW-DenW){1'b0}}, da_q};
        gcd_b_q <= {{(WordW-DenW){1'b0}}, db_q};
      end else begin
        gcd_a_q <= mag_w;
        gcd_b_q <= {{(WordW-RdW){1'b0}}, rd_w};
      end
    end else if (cmd_i.gcd_step) begin
      if (gcd_done) begin
        g_q <= gcd_res;
      end else if (!gcd_a_q[0] && !gcd_b_q[0]) begin
        gcd_a_q <= gcd_a_q >> 1;
        gcd_b_q <= gcd_b_q >> 1;
        gcd_k_q <= gcd_k_q + 1'b1;
      end else if (!gcd_a_q[0]) begin
        gcd_a_q <= gcd_a_q >> 1;
      end else if (!gcd_b_q[0]) begin
        gcd_b_q <= gcd_b_q >> 1;
      end else if (gcd_a_q >= gcd_b_q) begin
        gcd_a_q <= (gcd_a_q - gcd_b_q) >> 1;
      end else begin
        gcd_b_q <= (gcd_b_q - gcd_a_q) >> 1;
      end
    end
  end

  // divider
  always_comb begin
    case (cmd_i.div_dst)
      DDST_QA:  div_src = {{(WordW-DenW){1'b0}}, da_q};
      DDST_QB:  div_src = {{(WordW-DenW){1'b0}}, db_q};
      DDST_MAG: div_src = mag_q;
      DDST_RD:  div_src = {{(WordW-RdW){1'b0}}, rd_q};
      default:  div_src = mag_q;
    endcase
  end

  assign div_t    = {div_r_q, div_qt_q[WordW-1]};
  assign div_diff = div_t - {1'b0, g_q};
  assign div_ge   = div_t >= {1'b0, g_q};
  assign div_rn   = div_ge ? div_diff[WordW-1:0] : div_t[WordW-1:0];
  assign div_qn   = {div_qt_q[WordW-2:0], div_ge};
  assign div_last = div_cnt_q == ShW'(WordW - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_r_q   <= '0;
      div_qt_q  <= div_src;
      div_cnt_q <= '0;
      div_dst_q <= cmd_i.div_dst;
    end else if (cmd_i.div_step) begin
      div_r_q   <= div_rn;
      div_qt_q  <= div_qn;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // multiplier, one product per cycle
  always_comb begin
    op_a = {na_q[NumW-1], na_q};
    op_b = {nb_q[NumW-1], nb_q};
    case (cmd_i.mul_sel)
      MSEL_P0: begin
        op_a = {na_q[NumW-1], na_q};
        op_b = (act_q == ACT_MUL) ? {nb_q[NumW-1], nb_q} : {2'b00, qb_q};
      end
      MSEL_P1: begin
        if (act_q == ACT_MUL) begin
          op_a = {2'b00, da_q};
          op_b = {2'b00, db_q};
        end else begin
          op_a = {nb_q[NumW-1], nb_q};
          op_b = {2'b00, qa_q};
        end
      end
      MSEL_P2: begin
        op_a = {2'b00, qa_q};
        op_b = {2'b00, db_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MSEL_P0: p0_q <= prod[WordW-1:0];
        MSEL_P1: p1_q <= prod[WordW-1:0];
        MSEL_P2: p2_q <= prod[WordW-1:0];
        default: p2_q <= prod[WordW-1:0];
      endcase
    end
  end

  always_comb begin
    case (act_q)
      ACT_ADD: rn_w = p0_q + p1_q;
      ACT_SUB: rn_w = p0_q - p1_q;
      default: rn_w = p0_q;
    endcase
  end

  assign rd_w  = (act_q == ACT_MUL) ? p1_q[RdW-1:0] : p2_q[RdW-1:0];
  assign mag_w = rn_w[WordW-1] ? WordW'(-rn_w) : WordW'(rn_w);

  // result registers; a finished quotient lands in its destination
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      mag_q <= mag_w;
      rd_q  <= rd_w;
      neg_q <= rn_w[WordW-1];
    end else if (cmd_i.div_step && div_last) begin
      case (div_dst_q)
        DDST_QA:  qa_q  <= div_qn[DenW-1:0];
        DDST_QB:  qb_q  <= div_qn[DenW-1:0];
        DDST_MAG: mag_q <= div_qn;
        DDST_RD:  rd_q  <= div_qn[RdW-1:0];
        default:  mag_q <= div_qn;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        OK_NORM: begin
          num_q <= neg_q ? (~mag_q + 1'b1) : mag_q;
          den_q <= rd_q;
          st_q  <= 1'b0;
        end
        OK_ZERO: begin
          num_q <= '0;
          den_q <= RdW'(1);
          st_q  <= 1'b0;
        end
        OK_LCD: begin
          num_q <= '0;
          den_q <= p2_q[RdW-1:0];
          st_q  <= 1'b0;
        end
        default: begin
          num_q <= '0;
          den_q <= '0;
          st_q  <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.den_zero = (da_q == '0) || (db_q == '0);
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_last = div_last;
  assign sts_o.rn_zero  = rn_w == '0;
  assign sts_o.is_lcd   = act_q == ACT_LCD;

  assign num_out_o = num_q;
  assign den_out_o = den_q;
  assign status_o  = st_q;

endmodule

FILE: rtl/core/fau_ctrl.sv
module fau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fau_pkg::sts_t sts_i,
  output fau_pkg::cmd_t cmd_o
);
  import fau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_GCD1,
    S_DIVA_LD,
    S_DIVA,
    S_DIVB_LD,
    S_DIVB,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_RES,
    S_GCD2,
    S_DIVN_LD,
    S_DIVN,
    S_DIVD_LD,
    S_DIVD,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  okind_e kind_q, kind_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.gcd_load = 1'b1;
        cmd_o.gcd_src  = GSRC_DEN;
        if (sts_i.den_zero) begin
          kind_d  = OK_ERR;
          state_d = S_FIN;
        end else begin
          state_d = S_GCD1;
        end
      end
      S_GCD1: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) state_d = S_DIVA_LD;
      end
      S_DIVA_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_dst  = DDST_QA;
        state_d        = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DIVB_LD;
      end
      S_DIVB_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_dst  = DDST_QB;
        state_d        = S_DIVB;
      end
      S_DIVB: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MUL0;
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_P0;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_P1;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_P2;
        state_d       = S_RES;
      end
      S_RES: begin
        cmd_o.res_load = 1'b1;
        cmd_o.gcd_load = 1'b1;
        cmd_o.gcd_src  = GSRC_RES;
        if (sts_i.is_lcd) begin
          kind_d  = OK_LCD;
          state_d = S_FIN;
        end else if (sts_i.rn_zero) begin
          kind_d  = OK_ZERO;
          state_d = S_FIN;
        end else begin
          kind_d  = OK_NORM;
          state_d = S_GCD2;
        end
      end
      S_GCD2: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) state_d = S_DIVN_LD;
      end
      S_DIVN_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_dst  = DDST_MAG;
        state_d        = S_DIVN;
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DIVD_LD;
      end
      S_DIVD_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_dst  = DDST_RD;
        state_d        = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= OK_NORM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  // one item at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while busy");

  // a division stops after its last quotient bit
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step && sts_i.div_last) |=> !cmd_o.div_step)
    else $error("divider stepped past its last bit");

  // a new result only comes out of the final state
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result raised outside final state");
`endif

endmodule

FILE: rtl/core/fraction_arithmetic_unit.sv
// Rational arithmetic on two signed fractions (add, subtract, multiply, or
// least common denominator of the two denominators). Results are reduced by
// the GCD and carry the sign in the numerator; a zero result is 0/1 and a
// zero input denominator gives status 1 with both fields zero. One item is
// processed at a time. An add, subtract or multiply with a nonzero result
// runs two binary GCDs, four 32-step restoring divisions with their load
// states, and three multiplier products. The LCD action and a zero result
// skip the second GCD and the last two divisions; a zero denominator goes
// straight to the output. The next item is taken as soon as the result sits
// in the output register; a result still waiting there holds the next one
// in its final state.
module fraction_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // num_a[15:0], den_a[30:16], num_b[46:31], den_b[61:47], zero[63:62]
  input  logic [63:0] s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // num_out[31:0], den_out[61:32], zero[63:62]
  output logic [63:0] m_axis_tdata_o,
  // status[0]
  output logic        m_axis_tuser_o
);
  import fau_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [WordW-1:0] num_out;
  logic [RdW-1:0]   den_out;

  fau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fau_datapath u_datapath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .action_i  (s_axis_tuser_i),
    .num_a_i   (s_axis_tdata_i[15:0]),
    .den_a_i   (s_axis_tdata_i[30:16]),
    .num_b_i   (s_axis_tdata_i[46:31]),
    .den_b_i   (s_axis_tdata_i[61:47]),
    .num_out_o (num_out),
    .den_out_o (den_out),
    .status_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, den_out, num_out};

endmodule

FILE: verif/tb_fraction_arithmetic_unit.sv
module tb_fraction_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fau_pkg::*;

  typedef struct {
    act_e               act;
    logic signed [15:0] num_a;
    logic [14:0]        den_a;
    logic signed [15:0] num_b;
    logic [14:0]        den_b;
  } frac_op_t;

  typedef struct {
    logic [31:0] num;
    logic [29:0] den;
    logic        status;
  } frac_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  frac_res_t reduced_q[$];
  int        err_cnt = 0;
  bit        src_gaps = 1'b1;
  bit        sink_gaps = 1'b1;
  bit        long_hold_req = 1'b0;

  fraction_arithmetic_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic longint gcd_of(longint a, longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    longint na, nb, da, db, lcm, ta, tb, rn, rd, mag, g;
    frac_res_t r;
    r.num    = '0;
    r.den    = '0;
    r.status = 1'b0;
    na = op.num_a;
    nb = op.num_b;
    da = op.den_a;
    db = op.den_b;
    if (da == 0 || db == 0) begin
      r.status = 1'b1;
    end else begin
      lcm = (da / gcd_of(da, db)) * db;
      if (op.act == ACT_LCD) begin
        r.den = lcm[29:0];
      end else begin
        if (op.act == ACT_MUL) begin
          rn = na * nb;
          rd = da * db;
        end else begin
          ta = na * (lcm / da);
          tb = nb * (lcm / db);
          rn = (op.act == ACT_ADD) ? ta + tb : ta - tb;
          rd = lcm;
        end
        if (rn == 0) begin
          rd = 1;
        end else begin
          mag = (rn < 0) ? -rn : rn;
          g   = gcd_of(mag, rd);
          mag = mag / g;
          rd  = rd / g;
          rn  = (rn < 0) ? -mag : mag;
        end
        r.num = rn[31:0];
        r.den = rd[29:0];
      end
    end
    return r;
  endfunction

  // One transfer on the input side; the expectation is queued once it is taken.
  task automatic send_op(act_e act, logic [15:0] na, logic [14:0] da,
                         logic [15:0] nb, logic [14:0] db);
    frac_op_t op;
    op.act   = act;
    op.num_a = na;
    op.den_a = da;
    op.num_b = nb;
    op.den_b = db;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, db, nb, da, na};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reduced_q.push_back(reduce_fraction(op));
  endtask

  function automatic logic [14:0] pick_den();
    int k;
    case ($urandom_range(0, 31))
      0:              return '0;
      1, 2, 3:        return 15'd32767 - 15'($urandom_range(0, 3));
      4, 5, 6, 7, 8:  return 15'($urandom_range(1, 64));
      9, 10, 11, 12: begin
        k = $urandom_range(2, 360);
        return 15'($urandom_range(1, 32767 / k) * k);
      end
      default:        return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [15:0] pick_num();
    case ($urandom_range(0, 7))
      0:       return 16'($signed($urandom_range(0, 40)) - 20);
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2:       return 16'($urandom_range(1, 360) * $urandom_range(1, 90));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) begin
      send_op(act_e'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(), pick_den());
    end
  endtask

  task automatic test_directed();
    send_op(ACT_ADD, 16'd1, 15'd2, 16'd1, 15'd3);
    send_op(ACT_SUB, 16'd1, 15'd2, 16'd1, 15'd2);
    send_op(ACT_MUL, 16'd0, 15'd5, 16'd7, 15'd3);
    send_op(ACT_ADD, -16'sd1, 15'd32767, 16'd1, 15'd32767);
    send_op(ACT_LCD, 16'd5, 15'd32767, -16'sd5, 15'd32766);
    send_op(ACT_LCD, 16'd0, 15'd4, 16'd0, 15'd6);
    send_op(ACT_LCD, 16'd9, 15'd1, 16'd9, 15'd1);
    send_op(ACT_ADD, 16'h8000, 15'd32767, 16'h8000, 15'd32766);
    send_op(ACT_SUB, 16'h7fff, 15'd1, 16'h8000, 15'd1);
    send_op(ACT_SUB, 16'h8000, 15'd32766, 16'h7fff, 15'd32767);
    send_op(ACT_MUL, 16'h8000, 15'd32767, 16'h8000, 15'd32767);
    send_op(ACT_MUL, 16'h7fff, 15'd32767, 16'h8000, 15'd1);
    send_op(ACT_ADD, 16'd3, 15'd6, 16'd3, 15'd6);
    send_op(ACT_SUB, 16'd6, 15'd4, 16'd1, 15'd4);
    send_op(ACT_MUL, 16'd6, 15'd4, 16'd2, 15'd3);
    send_op(ACT_MUL, -16'sd1, 15'd1, 16'd1, 15'd1);
    // zero denominators: den_a for every action, den_b for add, multiply and LCD
    send_op(ACT_ADD, 16'd1, 15'd0, 16'd1, 15'd3);
    send_op(ACT_SUB, 16'd1, 15'd0, 16'd1, 15'd3);
    send_op(ACT_MUL, 16'd1, 15'd0, 16'd1, 15'd3);
    send_op(ACT_LCD, 16'd1, 15'd0, 16'd1, 15'd3);
    send_op(ACT_ADD, 16'h8000, 15'd7, 16'h7fff, 15'd0);
    send_op(ACT_MUL, 16'd2, 15'd9, 16'd3, 15'd0);
    send_op(ACT_LCD, 16'd0, 15'd0, 16'd0, 15'd0);
  endtask

  task automatic test_random_gaps(int n);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    send_random(n);
  endtask

  // Output held off long enough for the result register to block the input.
  task automatic test_output_stall();
    long_hold_req = 1'b1;
    send_random(20);
  endtask

  task automatic test_random_streaming(int n);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_random(n);
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst_n && m_tvalid && m_tready) begin
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual num %0d den %0d status %0d",
                 $time, $signed(m_tdata[31:0]), m_tdata[61:32], m_tuser);
        err_cnt++;
      end else begin
        exp_r = reduced_q.pop_front();
        if (m_tdata[31:0] !== exp_r.num) begin
          $display("%0t: num_out mismatch, expected %0d actual %0d",
                   $time, $signed(exp_r.num), $signed(m_tdata[31:0]));
          err_cnt++;
        end
        if (m_tdata[61:32] !== exp_r.den) begin
          $display("%0t: den_out mismatch, expected %0d actual %0d",
                   $time, exp_r.den, m_tdata[61:32]);
          err_cnt++;
        end
        if (m_tuser !== exp_r.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_r.status, m_tuser);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_gaps(700);
    test_output_stall();
    test_random_gaps(60);
    test_random_streaming(700);
    s_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
